// File: design/rar_pkg.sv
// Package for the rational arithmetic reducer: types, command codes and widths.
package rar_pkg;

	localparam int OperandWidth = 16;
	localparam int WordWidth    = 32;
	localparam int CmdWidth     = 3;
	localparam int QueueDepth   = 2;
	localparam int QueueIdxW    = 1;

	localparam logic [CmdWidth-1:0] CmdAdd = 3'd0;
	localparam logic [CmdWidth-1:0] CmdSub = 3'd1;
	localparam logic [CmdWidth-1:0] CmdMul = 3'd2;
	localparam logic [CmdWidth-1:0] CmdDiv = 3'd3;
	localparam logic [CmdWidth-1:0] CmdEqv = 3'd4;

	// Work handed from the front end to the reduction engine.
	typedef struct packed {
		logic                        eqv;
		logic                        zero_out;
		logic signed [WordWidth-1:0] n0;
		logic signed [WordWidth-1:0] d0;
		logic signed [WordWidth-1:0] n1;
		logic signed [WordWidth-1:0] d1;
	} job_t;

	// Result from the engine.
	typedef struct packed {
		logic signed [WordWidth-1:0] num;
		logic signed [WordWidth-1:0] den;
		logic                        equivalent;
	} res_t;

endpackage

// File: design/rar_front.sv
// Front end: accepts a transaction, registers the operands, then forms and registers the cross products.
module rar_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [rar_pkg::CmdWidth-1:0]      cmd,
	input  logic signed [rar_pkg::OperandWidth-1:0] a_num,
	input  logic signed [rar_pkg::OperandWidth-1:0] a_den,
	input  logic signed [rar_pkg::OperandWidth-1:0] b_num,
	input  logic signed [rar_pkg::OperandWidth-1:0] b_den,
	output logic                              job_valid,
	input  logic                              job_ready,
	output rar_pkg::job_t                     job
);
	localparam int W = rar_pkg::WordWidth;

	logic                    busy_q;
	logic                    phase_q;
	logic [rar_pkg::CmdWidth-1:0] cmd_q;
	logic signed [W-1:0]     an_q, ad_q, bn_q, bd_q;
	logic signed [W-1:0]     p0_q, p1_q, p2_q;
	logic signed [W-1:0]     m0, m1, m2;

	assign in_ready  = !busy_q;
	assign job_valid = busy_q && phase_q;

	// Three multiplies per cycle, selected by command.
	always_comb begin
		m0 = an_q * bd_q;
		m1 = ad_q * bn_q;
		m2 = ad_q * bd_q;
		if (cmd_q == rar_pkg::CmdMul) begin
			m0 = an_q * bn_q;
		end
	end

	// Build the job from the registered products, or from the operands for an equivalence test.
	always_comb begin
		job = '0;
		unique case (cmd_q)
			rar_pkg::CmdAdd: begin job.n0 = p0_q + p1_q; job.d0 = p2_q; end
			rar_pkg::CmdSub: begin job.n0 = p0_q - p1_q; job.d0 = p2_q; end
			rar_pkg::CmdMul: begin job.n0 = p0_q; job.d0 = p2_q; end
			rar_pkg::CmdDiv: begin job.n0 = p0_q; job.d0 = p1_q; end
			rar_pkg::CmdEqv: begin
				job.eqv = 1'b1;
				job.n0 = an_q; job.d0 = ad_q; job.n1 = bn_q; job.d1 = bd_q;
			end
			default: job.zero_out = 1'b1;
		endcase
	end

	// Busy and phase control; operand capture and product registers follow.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (!busy_q) begin
			if (in_valid) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
			end
		end else if (!phase_q) begin
			phase_q <= 1'b1;
		end else if (job_ready) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && in_valid) begin
			cmd_q <= cmd;
			an_q  <= W'(a_num);
			ad_q  <= W'(a_den);
			bn_q  <= W'(b_num);
			bd_q  <= W'(b_den);
		end
		if (busy_q && !phase_q) begin
			p0_q <= m0;
			p1_q <= m1;
			p2_q <= m2;
		end
	end
endmodule

// File: design/rar_queue.sv
// Short job queue between front end and engine.
module rar_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  rar_pkg::job_t wr_job,
	output logic          rd_valid,
	input  logic          rd_ready,
	output rar_pkg::job_t rd_job
);
	rar_pkg::job_t slot_q [rar_pkg::QueueDepth];
	logic [rar_pkg::QueueIdxW-1:0] wp_q, rp_q;
	logic [rar_pkg::QueueIdxW:0]   cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != (rar_pkg::QueueIdxW+1)'(rar_pkg::QueueDepth);
	assign rd_valid = cnt_q != '0;
	assign rd_job   = slot_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	// Pointer and count update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			if (wr && !rd) cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) slot_q[wp_q] <= wr_job;
	end
endmodule

// File: design/rar_divider.sv
// Restoring signed divider with truncating quotient and remainder, one bit a cycle.
module rar_divider (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [rar_pkg::WordWidth-1:0]   dividend,
	input  logic signed [rar_pkg::WordWidth-1:0]   divisor,
	output logic                                   done,
	output logic signed [rar_pkg::WordWidth-1:0]   quot,
	output logic signed [rar_pkg::WordWidth-1:0]   rem
);
	localparam int W = rar_pkg::WordWidth;

	logic            run_q;
	logic [5:0]      cnt_q;
	logic [W-1:0]    q_q, dv_q;
	logic [W-1:0]    r_q;
	logic            qneg_q, rneg_q;
	logic [W:0]      trial;
	logic [W:0]      shifted;
	logic [W-1:0]    ua, ub;

	assign ua = dividend[W-1] ? W'(-dividend) : W'(dividend);
	assign ub = divisor[W-1]  ? W'(-divisor)  : W'(divisor);
	assign shifted = {r_q, q_q[W-1]};
	assign trial   = shifted - {1'b0, dv_q};
	assign quot = qneg_q ? W'(-q_q) : W'(q_q);
	assign rem  = rneg_q ? W'(-r_q) : W'(r_q);

	// Iteration control: W steps then done for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'(W-1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q    <= ua;
			dv_q   <= ub;
			r_q    <= '0;
			qneg_q <= dividend[W-1] ^ divisor[W-1];
			rneg_q <= dividend[W-1];
		end else if (run_q) begin
			if (!trial[W]) begin
				r_q <= trial[W-1:0];
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= shifted[W-1:0];
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end
endmodule

// File: design/rar_engine.sv
// Back end: Euclidean gcd and division of each fraction, using one shared divider.
module rar_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_ready,
	input  rar_pkg::job_t job,
	output logic          res_valid,
	input  logic          res_ready,
	output rar_pkg::res_t res
);
	localparam int W = rar_pkg::WordWidth;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_LOAD = 7'b0000010,
		S_GCD  = 7'b0000100,
		S_DIVN = 7'b0001000,
		S_DIVD = 7'b0010000,
		S_NEXT = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q;
	logic            wait_q;
	logic            sel_q;
	rar_pkg::job_t   job_q;
	logic signed [W-1:0] n_q, d_q, x_q, y_q, g_q, rn0_q, rd0_q;
	logic            start;
	logic signed [W-1:0] dvd, dvs, quot, rem;
	logic            done;

	assign job_ready = state_q == S_IDLE;
	assign res_valid = state_q == S_OUT;

	rar_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(start), .dividend(dvd), .divisor(dvs),
		.done(done), .quot(quot), .rem(rem)
	);

	// Divider operands by state.
	always_comb begin
		start = 1'b0;
		dvd = x_q;
		dvs = y_q;
		unique case (state_q)
			S_GCD:  begin dvd = x_q; dvs = y_q; start = !wait_q && (y_q != '0); end
			S_DIVN: begin dvd = n_q; dvs = g_q; start = !wait_q; end
			S_DIVD: begin dvd = d_q; dvs = g_q; start = !wait_q; end
			default: start = 1'b0;
		endcase
	end

	// Sequencer over the one or two fractions of a job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wait_q  <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (job_valid) begin
					sel_q   <= 1'b0;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					wait_q <= 1'b0;
					if (job_q.zero_out || n_q == '0) state_q <= S_NEXT;
					else state_q <= S_GCD;
				end
				S_GCD: begin
					if (!wait_q) begin
						if (y_q == '0) state_q <= (x_q == '0) ? S_NEXT : S_DIVN;
						else wait_q <= 1'b1;
					end else if (done) wait_q <= 1'b0;
				end
				S_DIVN: begin
					if (!wait_q) wait_q <= 1'b1;
					else if (done) begin wait_q <= 1'b0; state_q <= S_DIVD; end
				end
				S_DIVD: begin
					if (!wait_q) wait_q <= 1'b1;
					else if (done) begin wait_q <= 1'b0; state_q <= S_NEXT; end
				end
				S_NEXT: begin
					if (job_q.eqv && !sel_q) begin
						sel_q <= 1'b1;
						state_q <= S_LOAD;
					end else state_q <= S_OUT;
				end
				S_OUT: if (res_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (job_valid) begin
				job_q <= job;
				n_q   <= job.n0;
				d_q   <= job.d0;
			end
			S_LOAD: begin
				x_q <= n_q[W-1] ? W'(-n_q) : n_q;
				y_q <= d_q;
			end
			S_GCD: begin
				if (!wait_q && y_q == '0) g_q <= x_q;
				if (wait_q && done) begin
					x_q <= y_q;
					y_q <= rem;
				end
			end
			S_DIVN: if (wait_q && done) n_q <= quot;
			S_DIVD: if (wait_q && done) d_q <= quot;
			S_NEXT: if (job_q.eqv && !sel_q) begin
				rn0_q <= n_q;
				rd0_q <= d_q;
				n_q   <= job_q.n1;
				d_q   <= job_q.d1;
			end
			default: begin end
		endcase
	end

	// Result forming.
	always_comb begin
		res = '0;
		if (job_q.zero_out) res = '0;
		else if (job_q.eqv) res.equivalent = (rn0_q == n_q) && (rd0_q == d_q);
		else begin
			res.num = n_q;
			res.den = d_q;
		end
	end
endmodule

// File: design/rational_arith_reduce.sv
// Top level of the rational arithmetic reducer.
// Usage: an input transaction on s_axis carries a command and two fractions a and b;
// for each one, exactly one result transaction leaves on m_axis.
// Commands are add, subtract, multiply, divide and equivalence test; unused codes give zeros.
// The front end registers the operands, forms the 32-bit cross products in a registered
// multiply step and pushes a job into a two-entry queue.
// The back end runs a Euclidean gcd on one shared 32-step restoring divider, then
// divides numerator and denominator by the gcd. An equivalence test reduces both
// fractions in turn; a zero numerator skips reduction.
// The front end accepts the next transaction while the back end works, until the
// queue is full. A stalled receiver holds the result in the back end, which then
// stops taking jobs, and the queue fills back to the input.
// Reset clears all handshake and sequencer state; no item is pending after it.
module rational_arith_reduce (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: cmd[2:0], a_num[18:3], a_den[34:19], b_num[50:35], b_den[66:51], zeros to 71
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: res_num[31:0], res_den[63:32], equivalent[64], zeros to 71
	output logic [71:0] m_axis_tdata
);
	logic          jv, jr, qv, qr;
	rar_pkg::job_t fj, qj;
	rar_pkg::res_t r;

	rar_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.cmd(s_axis_tdata[2:0]), .a_num(s_axis_tdata[18:3]), .a_den(s_axis_tdata[34:19]),
		.b_num(s_axis_tdata[50:35]), .b_den(s_axis_tdata[66:51]),
		.job_valid(jv), .job_ready(jr), .job(fj)
	);

	rar_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(jv), .wr_ready(jr), .wr_job(fj),
		.rd_valid(qv), .rd_ready(qr), .rd_job(qj)
	);

	rar_engine u_engine (
		.clk(clk), .arst_n(arst_n), .job_valid(qv), .job_ready(qr), .job(qj),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(r)
	);

	assign m_axis_tdata = {7'd0, r.equivalent, r.den, r.num};
endmodule
